// File: hdl/wabp_pkg.sv
// Shared types and constants for the word-aligned byte packer.
// Used by wabp_pack_core and word_aligned_byte_packer_unit; depends on nothing.
package wabp_pkg;

  // Word geometry: four byte lanes, addressed by a two-bit lane number.
  localparam int LANES_PER_WORD = 4;
  localparam int LANE_BITS = 2;
  localparam int BYTE_BITS = 8;
  localparam int WORD_BITS = LANES_PER_WORD * BYTE_BITS;
  localparam int INDEX_BITS = 12;

  // Default wrap point of the word offset.
  localparam int MAX_WORDS_DEFAULT = 4096;

  // Lane whose filling completes a word.
  localparam logic [LANE_BITS-1:0] TOP_LANE = LANE_BITS'(LANES_PER_WORD - 1);

  // One source byte of a copy.
  typedef struct packed {
    logic [BYTE_BITS-1:0] data_byte;
    logic [LANE_BITS-1:0] start_lane;
    logic                 first_byte;
    logic                 last_byte;
  } wabp_in_t;

  // One word write toward the destination.
  typedef struct packed {
    logic [WORD_BITS-1:0]      word_data;
    logic [LANES_PER_WORD-1:0] byte_enable;
    logic [INDEX_BITS-1:0]     word_index;
    logic                      last_word;
  } wabp_out_t;

endpackage

// File: hdl/word_aligned_byte_packer_unit.sv
// Top level of the word-aligned byte packer: input register, packing core, result register.
// Depends on wabp_pkg and wabp_pack_core.

// The packer takes one byte per cycle and packs each copy little-endian into
// 32-bit words, starting at the lane carried on the first byte. It issues one
// write per filled word and a final, possibly partial, write when the last
// byte arrives; byte_enable names the lanes that hold source bytes and the
// word index counts words from the start of the copy, wrapping at MAX_WORDS.
// A byte is captured in the input register and its word, if any, is loaded
// from there into the result register. Throughput is one byte per cycle;
// input is held back only while the result register is occupied and not
// taken and the held byte completes another word.
module word_aligned_byte_packer_unit #(
  parameter int MAX_WORDS = wabp_pkg::MAX_WORDS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_ready,
  input  wabp_pkg::wabp_in_t  byte_item,
  output logic                word_valid,
  input  logic                word_ready,
  output wabp_pkg::wabp_out_t word_item
);
  import wabp_pkg::*;

  logic      hold_valid;
  wabp_in_t  hold_item;
  logic      advance;
  logic      emit;
  wabp_out_t result;

  // The held byte moves on unless its word would land on an untaken result.
  assign advance    = hold_valid && (!emit || !word_valid || word_ready);
  assign byte_ready = !hold_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (byte_ready) begin
      hold_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) begin
      hold_item <= byte_item;
    end
  end

  wabp_pack_core #(
    .MAX_WORDS(MAX_WORDS)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .step  (advance),
    .item  (hold_item),
    .emit  (emit),
    .result(result)
  );

  // Result register: loaded by a word write, cleared by its transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (advance && emit) begin
      word_valid <= 1'b1;
    end else if (word_ready) begin
      word_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      word_item <= result;
    end
  end

  // Every write carries at least one source byte.
  a_enable_nonzero : assert property (@(posedge clk) disable iff (rst)
    word_valid |-> (word_item.byte_enable != '0))
    else $error("word write with empty byte enable");

  // A write that does not end a copy was caused by filling the top lane.
  a_full_word_top_lane : assert property (@(posedge clk) disable iff (rst)
    (word_valid && !word_item.last_word) |-> word_item.byte_enable[LANES_PER_WORD-1])
    else $error("mid-copy write without top lane");

  // An empty input register always accepts a byte.
  a_empty_hold_ready : assert property (@(posedge clk) disable iff (rst)
    !hold_valid |-> byte_ready)
    else $error("input register empty but not ready");

  // The input stalls only behind an occupied, untaken result.
  a_stall_cause : assert property (@(posedge clk) disable iff (rst)
    !byte_ready |-> (hold_valid && emit && word_valid && !word_ready))
    else $error("input stalled without a blocked result");

endmodule

// File: hdl/wabp_pack_core.sv
// Packing state and next-state logic of the word-aligned byte packer.
// Depends on wabp_pkg for the item types and word geometry.
module wabp_pack_core #(
  parameter int MAX_WORDS = wabp_pkg::MAX_WORDS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  wabp_pkg::wabp_in_t  item,
  output logic                emit,
  output wabp_pkg::wabp_out_t result
);
  import wabp_pkg::*;

  localparam int CNT_BITS = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(MAX_WORDS - 1);

  logic [WORD_BITS-1:0]      assembly_word;
  logic [LANES_PER_WORD-1:0] lane_mask;
  logic [LANE_BITS-1:0]      next_lane;
  logic [CNT_BITS-1:0]       word_counter;

  logic [WORD_BITS-1:0]      assembly_word_next;
  logic [LANES_PER_WORD-1:0] lane_mask_next;
  logic [LANE_BITS-1:0]      next_lane_next;
  logic [CNT_BITS-1:0]       word_counter_next;

  logic [LANE_BITS-1:0]      lane;
  logic [WORD_BITS-1:0]      word_base;
  logic [LANES_PER_WORD-1:0] mask_base;
  logic [CNT_BITS-1:0]       count_base;
  logic [WORD_BITS-1:0]      word_merged;
  logic [LANES_PER_WORD-1:0] mask_merged;
  logic [CNT_BITS-1:0]       count_inc;

  // A first byte restarts the copy at its own lane with empty gathered state.
  always_comb begin
    lane       = item.first_byte ? item.start_lane : next_lane;
    word_base  = item.first_byte ? '0 : assembly_word;
    mask_base  = item.first_byte ? '0 : lane_mask;
    count_base = item.first_byte ? '0 : word_counter;
  end

  // Merge the byte into its lane and decide whether a word write is due.
  always_comb begin
    word_merged = word_base |
                  (WORD_BITS'(item.data_byte) << (BYTE_BITS * int'(lane)));
    mask_merged = mask_base | (LANES_PER_WORD'(1) << lane);
    emit        = (lane == TOP_LANE) || item.last_byte;
    count_inc   = (count_base == CNT_LAST) ? '0 : count_base + CNT_BITS'(1);

    result.word_data   = word_merged;
    result.byte_enable = mask_merged;
    result.word_index  = INDEX_BITS'(count_base);
    result.last_word   = item.last_byte;
  end

  // State after this byte: cleared at end of copy, advanced on a full word.
  always_comb begin
    if (item.last_byte) begin
      assembly_word_next = '0;
      lane_mask_next     = '0;
      next_lane_next     = '0;
      word_counter_next  = '0;
    end else if (emit) begin
      assembly_word_next = '0;
      lane_mask_next     = '0;
      next_lane_next     = '0;
      word_counter_next  = count_inc;
    end else begin
      assembly_word_next = word_merged;
      lane_mask_next     = mask_merged;
      next_lane_next     = lane + LANE_BITS'(1);
      word_counter_next  = count_base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      assembly_word <= '0;
      lane_mask     <= '0;
      next_lane     <= '0;
      word_counter  <= '0;
    end else if (step) begin
      assembly_word <= assembly_word_next;
      lane_mask     <= lane_mask_next;
      next_lane     <= next_lane_next;
      word_counter  <= word_counter_next;
    end
  end

endmodule
